// ===== src/hrm_pkg.sv =====
// ============================================================================
// hrm_pkg
// Types and constants shared by the heightfield ray marcher modules.
// ============================================================================
`default_nettype none

package hrm_pkg;

    // Fixed-point format of all coordinates: signed Q16.16.
    localparam int Q_W      = 32;
    localparam int FRAC_W   = 16;
    localparam int HEIGHT_W = 24;

    // Product of a 32-bit direction and the Q16.16 value 0.1.
    localparam int TENTH_W  = 46;
    localparam logic signed [13:0] STEP_TENTH = 14'sd6554;

    // Scaled height (24 x 32 bits) and the sum with the base height.
    localparam int PROD_W   = HEIGHT_W + Q_W;
    localparam int GROUND_W = PROD_W + 2;

    // Axis positions inside a coordinate vector.
    localparam int AXIS_X = 0;
    localparam int AXIS_Y = 1;
    localparam int AXIS_Z = 2;

    // Request function codes.
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_RAY   = 1'b1;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Z     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_SCALE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_HEIGHT  = 2'd3;

    localparam logic [Q_W-1:0] SCALE_RESET = 32'h0001_0000;

    typedef logic [Q_W-1:0] q16_t;
    typedef logic [2:0][Q_W-1:0] vec3_t;

    typedef struct packed {
        logic                func;
        logic [7:0]          cell_u;
        logic [7:0]          cell_v;
        logic [HEIGHT_W-1:0] height_value;
        logic signed [31:0]  start_x;
        logic signed [31:0]  start_y;
        logic signed [31:0]  start_z;
        logic signed [31:0]  dir_x;
        logic signed [31:0]  dir_y;
        logic signed [31:0]  dir_z;
    } ray_in_t;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
    } ray_out_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LEVEL1,
        ST_LEVEL2,
        ST_FINISH
    } ctl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic write;   // store one height cell from the input request
        logic start;   // load start point and direction of a ray
        logic issue;   // advance the point one step and probe it
        logic backup;  // restore the point before the hit, flush probes
        logic level2;  // switch to the fine step
        logic emit;    // load the output register
        logic found;   // hit bit of the emitted result
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic hit;       // oldest probe in flight lies below the terrain
        logic busy;      // probes still in flight
        logic out_free;  // output register can take a result this cycle
    } dp_status_t;

endpackage

`default_nettype wire

// ===== src/hrm_ram.sv =====
// ============================================================================
// hrm_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read.
// ============================================================================
`default_nettype none

module hrm_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== src/hrm_datapath.sv =====
// ============================================================================
// hrm_datapath
// Height store, configuration registers, march point and the three-stage
// probe pipeline (cell lookup, height scaling, ground compare).
// ============================================================================
`default_nettype none

module hrm_datapath #(
    parameter int MAP_SIZE = 256
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire hrm_pkg::dp_cmd_t                cmd,
    output      hrm_pkg::dp_status_t             status,
    input  wire hrm_pkg::ray_in_t                in_data,
    input  wire logic                            out_stall,
    output      logic                            out_valid,
    output      hrm_pkg::ray_out_t               out_data,
    input  wire logic                            cfg_wr_en,
    input  wire logic [hrm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [hrm_pkg::Q_W-1:0]         cfg_wdata
);

    localparam int CW    = $clog2(MAP_SIZE);
    localparam int AW    = 2 * CW;
    localparam int DEPTH = 1 << AW;

    // Configuration.
    hrm_pkg::q16_t offset_x_reg;
    hrm_pkg::q16_t offset_z_reg;
    hrm_pkg::q16_t height_scale_reg;
    hrm_pkg::q16_t base_height_reg;

    // Ray state.
    hrm_pkg::vec3_t point_reg;
    hrm_pkg::vec3_t prev_reg;
    hrm_pkg::vec3_t step_reg;
    hrm_pkg::vec3_t dir_reg;
    logic signed [hrm_pkg::TENTH_W-1:0] tenth_reg [3];
    hrm_pkg::vec3_t fine_step;

    // Probe pipeline.
    logic           probe_valid_reg;
    logic           s1_valid_reg;
    logic           s1_in_map_reg;
    hrm_pkg::q16_t  s1_y_reg;
    hrm_pkg::vec3_t s1_prev_reg;
    logic           s2_valid_reg;
    logic           s2_in_map_reg;
    hrm_pkg::q16_t  s2_y_reg;
    hrm_pkg::vec3_t s2_prev_reg;
    logic [hrm_pkg::PROD_W-1:0] s2_prod_reg;

    logic                 out_valid_reg;
    hrm_pkg::ray_out_t    out_data_reg;

    // Cell lookup.
    logic signed [32:0] dx;
    logic signed [32:0] dz;
    logic               x_in_map;
    logic               z_in_map;
    logic [CW-1:0]      u_idx;
    logic [CW-1:0]      v_idx;
    logic [AW-1:0]      raddr;
    logic [AW-1:0]      waddr;
    logic               wr_en;
    logic [hrm_pkg::HEIGHT_W-1:0] rdata;
    logic [hrm_pkg::PROD_W-1:0]   scaled;
    logic signed [hrm_pkg::GROUND_W-1:0] ground;
    logic signed [hrm_pkg::GROUND_W-1:0] y_ext;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_x_reg     <= '0;
            offset_z_reg     <= '0;
            height_scale_reg <= hrm_pkg::SCALE_RESET;
            base_height_reg  <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                hrm_pkg::CFG_OFFSET_X:     offset_x_reg     <= cfg_wdata;
                hrm_pkg::CFG_OFFSET_Z:     offset_z_reg     <= cfg_wdata;
                hrm_pkg::CFG_HEIGHT_SCALE: height_scale_reg <= cfg_wdata;
                hrm_pkg::CFG_BASE_HEIGHT:  base_height_reg  <= cfg_wdata;
                default:                   offset_x_reg     <= offset_x_reg;
            endcase
        end
    end

    // Height writes outside the map are dropped.
    assign wr_en = cmd.write
                   && (32'(in_data.cell_u) < 32'(MAP_SIZE))
                   && (32'(in_data.cell_v) < 32'(MAP_SIZE));
    assign waddr = {CW'(in_data.cell_v), CW'(in_data.cell_u)};

    // The cell index truncates toward zero, so anything in (-1.0, 0) past
    // the origin still lands on cell 0.
    always_comb
    begin
        dx = $signed({point_reg[hrm_pkg::AXIS_X][31], point_reg[hrm_pkg::AXIS_X]})
             - $signed({offset_x_reg[31], offset_x_reg});
        dz = $signed({point_reg[hrm_pkg::AXIS_Z][31], point_reg[hrm_pkg::AXIS_Z]})
             - $signed({offset_z_reg[31], offset_z_reg});
        x_in_map = (!dx[32] && (dx[32:16] < 17'(MAP_SIZE)))
                   || ((dx[32:16] == '1) && (dx[15:0] != '0));
        z_in_map = (!dz[32] && (dz[32:16] < 17'(MAP_SIZE)))
                   || ((dz[32:16] == '1) && (dz[15:0] != '0));
        u_idx = dx[32] ? '0 : dx[16 +: CW];
        v_idx = dz[32] ? '0 : dz[16 +: CW];
        raddr = {v_idx, u_idx};
    end

    hrm_ram #(
        .WIDTH (hrm_pkg::HEIGHT_W),
        .DEPTH (DEPTH)
    ) u_height_store (
        .clk   (clk),
        .we    (wr_en),
        .waddr (waddr),
        .wdata (in_data.height_value),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign scaled = rdata * height_scale_reg;

    // Fine step: dir * 0.1, truncated toward zero.
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            logic signed [hrm_pkg::TENTH_W-1:0] adj;
            adj = tenth_reg[a] + (tenth_reg[a][hrm_pkg::TENTH_W-1]
                  ? hrm_pkg::TENTH_W'(16'hFFFF) : hrm_pkg::TENTH_W'(0));
            fine_step[a] = {{2{adj[hrm_pkg::TENTH_W-1]}}, adj[hrm_pkg::TENTH_W-1:16]};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int a = 0; a < 3; a++)
        begin
            tenth_reg[a] <= hrm_pkg::TENTH_W'($signed(dir_reg[a]) * hrm_pkg::STEP_TENTH);
        end

        if (cmd.start)
        begin
            point_reg <= {in_data.start_z, in_data.start_y, in_data.start_x};
            step_reg  <= {in_data.dir_z, in_data.dir_y, in_data.dir_x};
            dir_reg   <= {in_data.dir_z, in_data.dir_y, in_data.dir_x};
        end
        else if (cmd.backup)
        begin
            point_reg <= s2_prev_reg;
        end
        else if (cmd.issue)
        begin
            prev_reg <= point_reg;
            for (int a = 0; a < 3; a++)
            begin
                point_reg[a] <= point_reg[a] + step_reg[a];
            end
        end

        if (cmd.level2)
        begin
            step_reg <= fine_step;
        end

        s1_in_map_reg <= x_in_map && z_in_map;
        s1_y_reg      <= point_reg[hrm_pkg::AXIS_Y];
        s1_prev_reg   <= prev_reg;

        s2_in_map_reg <= s1_in_map_reg;
        s2_y_reg      <= s1_y_reg;
        s2_prev_reg   <= s1_prev_reg;
        s2_prod_reg   <= scaled;

        if (cmd.emit)
        begin
            out_data_reg.hit     <= cmd.found;
            out_data_reg.point_x <= point_reg[hrm_pkg::AXIS_X];
            out_data_reg.point_y <= point_reg[hrm_pkg::AXIS_Y];
            out_data_reg.point_z <= point_reg[hrm_pkg::AXIS_Z];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            probe_valid_reg <= 1'b0;
            s1_valid_reg    <= 1'b0;
            s2_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            probe_valid_reg <= cmd.issue;
            s1_valid_reg    <= probe_valid_reg && !cmd.backup;
            s2_valid_reg    <= s1_valid_reg && !cmd.backup;
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        ground = $signed({2'b00, s2_prod_reg})
                 + $signed({{(hrm_pkg::GROUND_W - 32){base_height_reg[31]}}, base_height_reg});
        y_ext  = $signed({{(hrm_pkg::GROUND_W - 32){s2_y_reg[31]}}, s2_y_reg});
        status.hit      = s2_valid_reg && s2_in_map_reg && (y_ext < ground);
        status.busy     = probe_valid_reg || s1_valid_reg || s2_valid_reg;
        status.out_free = !out_valid_reg || !out_stall;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

// ===== src/hrm_ctrl.sv =====
// ============================================================================
// hrm_ctrl
// Controller of the ray marcher: request intake, step issue per level,
// back-up on a hit and result hand-off.
// ============================================================================
`default_nettype none

module hrm_ctrl #(
    parameter int MAX_STEPS = 1000
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire logic                in_func,
    output      logic                in_stall,
    output      hrm_pkg::dp_cmd_t    cmd,
    input  wire hrm_pkg::dp_status_t status
);

    localparam int CNT_W = $clog2(MAX_STEPS + 1);

    hrm_pkg::ctl_state_t state_reg;
    hrm_pkg::ctl_state_t state_next;
    logic [CNT_W-1:0]    cnt_reg;
    logic [CNT_W-1:0]    cnt_next;
    logic                found_reg;
    logic                found_next;
    logic                marching;
    logic                all_issued;
    logic                level_done;

    assign marching   = (state_reg == hrm_pkg::ST_LEVEL1) || (state_reg == hrm_pkg::ST_LEVEL2);
    assign all_issued = (cnt_reg == CNT_W'(MAX_STEPS));
    assign level_done = all_issued && !status.busy && !status.hit;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            hrm_pkg::ST_IDLE:
            begin
                if (in_valid && (in_func == hrm_pkg::FUNC_RAY))
                begin
                    state_next = hrm_pkg::ST_LEVEL1;
                end
            end
            hrm_pkg::ST_LEVEL1:
            begin
                if (status.hit)
                begin
                    state_next = hrm_pkg::ST_LEVEL2;
                end
                else if (level_done)
                begin
                    state_next = hrm_pkg::ST_FINISH;
                end
            end
            hrm_pkg::ST_LEVEL2:
            begin
                if (status.hit || level_done)
                begin
                    state_next = hrm_pkg::ST_FINISH;
                end
            end
            hrm_pkg::ST_FINISH:
            begin
                if (status.out_free)
                begin
                    state_next = hrm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = hrm_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall   = (state_reg != hrm_pkg::ST_IDLE);
        cmd.write  = (state_reg == hrm_pkg::ST_IDLE) && in_valid
                     && (in_func == hrm_pkg::FUNC_WRITE);
        cmd.start  = (state_reg == hrm_pkg::ST_IDLE) && in_valid
                     && (in_func == hrm_pkg::FUNC_RAY);
        cmd.issue  = marching && !status.hit && !all_issued;
        cmd.backup = marching && status.hit;
        cmd.level2 = (state_reg == hrm_pkg::ST_LEVEL1) && status.hit;
        cmd.emit   = (state_reg == hrm_pkg::ST_FINISH) && status.out_free;
        cmd.found  = found_reg;
    end

    always_comb
    begin
        cnt_next   = cnt_reg;
        found_next = found_reg;
        if (cmd.start)
        begin
            cnt_next   = '0;
            found_next = 1'b0;
        end
        else if (cmd.level2)
        begin
            cnt_next   = '0;
            found_next = 1'b1;
        end
        else if (cmd.issue)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hrm_pkg::ST_IDLE;
            cnt_reg   <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            found_reg <= found_next;
        end
    end

`ifndef SYNTHESIS
    // The step counter never runs past the level length.
    a_cnt_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_STEPS))
        else $error("step counter beyond level length");

    // A back-up flushes every probe still in flight.
    a_backup_flush: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.backup |=> !status.busy)
        else $error("probes left in flight after back-up");

    // A result is only loaded when the output register can take it.
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> status.out_free)
        else $error("result loaded over a waiting result");

    // The fine level is only entered with the found flag set by a coarse hit.
    a_found_level2: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == hrm_pkg::ST_LEVEL2) |-> found_reg)
        else $error("fine level entered without a coarse hit");
`endif

endmodule

`default_nettype wire

// ===== src/heightfield_ray_march.sv =====
// ============================================================================
// heightfield_ray_march
// Heightfield ray marcher: a height map written cell by cell and a
// two-level fixed-point ray march against it.
// ============================================================================
// Usage: requests arrive on in_valid/in_stall/in_data. A request with func
// clear writes one height cell and gives no result. A request with func set
// casts a ray; the single result leaves on out_valid/out_stall/out_data.
// Registers are written through cfg_wr_en/cfg_index/cfg_wdata; the user
// must write them only while no ray is in progress, which the block itself
// does not enforce. Each level probes one step per cycle, until a hit or
// its last step, through a three-stage pipeline (cell address, height
// store read and scaling, ground compare). One request is processed at a
// time: in_stall is high from the cycle after a ray is taken until its
// result has been loaded into the output register. A result waiting under
// out_stall holds its data; the next request is taken meanwhile, and a
// following ray result waits in the controller until the output register
// frees. Reset clears control state and restores the register defaults;
// the height store holds no defined contents until written.
// ============================================================================
`default_nettype none

module heightfield_ray_march #(
    parameter int MAP_SIZE  = 256,
    parameter int MAX_STEPS = 1000
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output      logic                          in_stall,
    input  wire hrm_pkg::ray_in_t              in_data,
    output      logic                          out_valid,
    input  wire logic                          out_stall,
    output      hrm_pkg::ray_out_t             out_data,
    input  wire logic                          cfg_wr_en,
    input  wire logic [hrm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [hrm_pkg::Q_W-1:0]       cfg_wdata
);

    hrm_pkg::dp_cmd_t    cmd;
    hrm_pkg::dp_status_t status;

    hrm_ctrl #(
        .MAX_STEPS (MAX_STEPS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_func  (in_data.func),
        .in_stall (in_stall),
        .cmd      (cmd),
        .status   (status)
    );

    hrm_datapath #(
        .MAP_SIZE (MAP_SIZE)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_data   (in_data),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_data  (out_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

endmodule

`default_nettype wire
